// ===== rtl/vdh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector dedup hash table package
// Shared payload types, command and status groups, states and codes.
// ----------------------------------------------------------------------------
package vdh_pkg;

  localparam logic       CMD_PUSH   = 1'b0;
  localparam logic       CMD_CLEAR  = 1'b1;
  localparam logic       REG_VECTOR_LENGTH = 1'b0;  // register index, paddr[2]
  localparam logic [6:0] LEN_RESET  = 7'd16;
  localparam logic [31:0] HASH_INIT = 32'h811C_9DC5;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] element;
  } vdh_in_t;

  typedef struct packed {
    logic [7:0] vector_index;
    logic [7:0] unique_id;
    logic       is_new;
    logic [8:0] distinct_count;
    logic       overflow;
  } vdh_out_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_EMIT
  } vdh_state_t;

  typedef enum logic [1:0] {
    RES_NEW,
    RES_FOUND,
    RES_FULL,
    RES_CAP
  } vdh_kind_t;

  typedef struct packed {
    logic      ready;       // input channel may transfer
    logic      push;        // store one element
    logic      clear;       // zero counters, restart sweep
    logic      sweep_step;  // empty one slot
    logic      probe_rd;    // read slot at probe index
    logic      probe_next;  // advance probe index
    logic      cmp_start;   // restart element compare
    logic      cmp_rd;      // read both rows at compare index
    logic      cmp_next;    // advance compare index
    logic      emit;        // load result register
    vdh_kind_t kind;
  } vdh_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic last_elem;
    logic cap_full;
    logic sweep_done;
    logic slot_valid;
    logic tag_hit;
    logic probes_last;
    logic cmp_equal;
    logic cmp_last;
    logic out_free;
  } vdh_stat_t;

endpackage
`default_nettype wire

// ===== rtl/vdh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector dedup controller
// Sequences element intake, table sweep, probing, row compare and result.
// ----------------------------------------------------------------------------
module vdh_ctrl
  import vdh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_cmd,
  input  wire vdh_stat_t stat,
  output vdh_cmd_t       cmd
);

  vdh_state_t state, state_next;
  vdh_kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      kind  <= RES_NEW;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.kind   = kind;
    case (state)
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_CLEAR) begin
            cmd.clear  = 1'b1;
            state_next = ST_SWEEP;
          end else begin
            cmd.push = 1'b1;
            if (stat.last_elem) begin
              if (stat.cap_full) begin
                kind_next  = RES_CAP;
                state_next = ST_EMIT;
              end else begin
                state_next = ST_PROBE_RD;
              end
            end
          end
        end
      end
      ST_PROBE_RD: begin
        cmd.probe_rd = 1'b1;
        state_next   = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (!stat.slot_valid) begin
          kind_next  = RES_NEW;
          state_next = ST_EMIT;
        end else if (stat.tag_hit) begin
          cmd.cmp_start = 1'b1;
          state_next    = ST_CMP_RD;
        end else if (stat.probes_last) begin
          kind_next  = RES_FULL;
          state_next = ST_EMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = ST_PROBE_RD;
        end
      end
      ST_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_next = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (!stat.cmp_equal) begin
          if (stat.probes_last) begin
            kind_next  = RES_FULL;
            state_next = ST_EMIT;
          end else begin
            cmd.probe_next = 1'b1;
            state_next     = ST_PROBE_RD;
          end
        end else if (stat.cmp_last) begin
          kind_next  = RES_FOUND;
          state_next = ST_EMIT;
        end else begin
          cmd.cmp_next = 1'b1;
          state_next   = ST_CMP_RD;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_SWEEP;
    endcase
    // A length write empties the table whatever the state.
    if (stat.cfg_wr) begin
      cmd        = '0;
      cmd.kind   = kind;
      cmd.clear  = 1'b1;
      state_next = ST_SWEEP;
    end
  end

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && stat.out_free && !stat.cfg_wr) |=> state == ST_IDLE)
    else $error("result not retired from emit");
  a_probe_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE_RD && !stat.cfg_wr) |=> state == ST_PROBE_CHK)
    else $error("probe read not followed by check");
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> state == ST_SWEEP)
    else $error("clear did not start sweep");

endmodule
`default_nettype wire

// ===== rtl/vdh_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vector dedup datapath
// Vector store, slot table, hash, counters, config register, result register.
// ----------------------------------------------------------------------------
module vdh_dp
  import vdh_pkg::*;
#(
  parameter int MAX_VECTORS = 256,
  parameter int MAX_DIM     = 64,
  parameter int TABLE_SLOTS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire vdh_cmd_t    cmd,
  output vdh_stat_t        stat,
  input  wire vdh_in_t     in_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             out_valid,
  input  wire logic        out_stall,
  output vdh_out_t         out_data
);

  localparam int VW  = $clog2(MAX_VECTORS + 1);
  localparam int RW  = $clog2(MAX_VECTORS);
  localparam int EIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW  = $clog2(MAX_DIM + 1);
  localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SLW = 33 + RW;
  localparam int VDEPTH = MAX_VECTORS * (2 ** EIW);
  localparam logic [SW:0]   SLOTS_W   = (SW + 1)'(TABLE_SLOTS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(TABLE_SLOTS - 1);

  logic [15:0]    vmem [VDEPTH];
  logic [SLW-1:0] smem [TABLE_SLOTS];

  logic [6:0]     cfg_len;
  logic [LW-1:0]  len_eff;
  logic [EIW-1:0] ec, k;
  logic [VW-1:0]  vc, dc;
  logic [31:0]    hash, hash_next;
  logic [SW-1:0]  slot_idx, sweep_idx, start_idx;
  logic [SW:0]    probes;
  logic [SLW-1:0] slot_rd;
  logic [15:0]    rda, rdb;
  logic           cfg_wr, clr;
  logic [RW-1:0]  slot_id;

  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_VECTOR_LENGTH);
  assign clr     = cmd.clear;
  assign prdata  = {25'd0, cfg_len};
  assign slot_id = slot_rd[RW-1:0];

  always_comb begin
    if (cfg_len == 7'd0) begin
      len_eff = LW'(1);
    end else if (int'(cfg_len) > MAX_DIM) begin
      len_eff = LW'(MAX_DIM);
    end else begin
      len_eff = LW'(cfg_len);
    end
  end

  // Rotate-xor tag over the elements; a full compare settles every hit.
  always_comb begin
    logic [31:0] h;
    h         = (ec == '0) ? HASH_INIT : hash;
    hash_next = {h[26:0], h[31:27]} ^ {16'd0, in_data.element};
    if ({1'b0, hash_next[SW-1:0]} >= SLOTS_W) begin
      start_idx = hash_next[SW-1:0] - SLOTS_W[SW-1:0];
    end else begin
      start_idx = hash_next[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= LEN_RESET;
    end else if (cfg_wr) begin
      cfg_len <= pwdata[6:0];
    end
  end

  // Counters and sweep pointer
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      ec        <= '0;
      vc        <= '0;
      dc        <= '0;
      sweep_idx <= '0;
    end else begin
      if (cmd.push) begin
        ec <= stat.last_elem ? '0 : ec + EIW'(1);
      end
      if (cmd.sweep_step && !stat.sweep_done) begin
        sweep_idx <= sweep_idx + SW'(1);
      end
      if (cmd.emit && (cmd.kind == RES_NEW || cmd.kind == RES_FOUND)) begin
        vc <= vc + VW'(1);
      end
      if (cmd.emit && cmd.kind == RES_NEW) begin
        dc <= dc + VW'(1);
      end
    end
  end

  // Probe and compare pointers
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hash     <= hash_next;
      slot_idx <= start_idx;
      probes   <= '0;
    end else if (cmd.probe_next) begin
      slot_idx <= (slot_idx == SLOT_LAST) ? '0 : slot_idx + SW'(1);
      probes   <= probes + (SW + 1)'(1);
    end
    if (cmd.cmp_start) begin
      k <= '0;
    end else if (cmd.cmp_next) begin
      k <= k + EIW'(1);
    end
  end

  // Vector store
  always_ff @(posedge clk) begin
    if (cmd.push && !stat.cap_full) begin
      vmem[{vc[RW-1:0], ec}] <= in_data.element;
    end
    if (cmd.cmp_rd) begin
      rda <= vmem[{vc[RW-1:0], k}];
      rdb <= vmem[{slot_id, k}];
    end
  end

  // Slot table: valid, tag, vector id
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      smem[sweep_idx] <= '0;
    end else if (cmd.emit && cmd.kind == RES_NEW) begin
      smem[slot_idx] <= {1'b1, hash, vc[RW-1:0]};
    end
    if (cmd.probe_rd) begin
      slot_rd <= smem[slot_idx];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.vector_index   <= (cmd.kind == RES_CAP) ? 8'(MAX_VECTORS) : 8'(vc);
      out_data.unique_id      <= (cmd.kind == RES_NEW)   ? 8'(vc) :
                                 (cmd.kind == RES_FOUND) ? 8'(slot_id) : 8'd0;
      out_data.is_new         <= (cmd.kind == RES_NEW);
      out_data.distinct_count <= (cmd.kind == RES_NEW) ? 9'(dc + VW'(1)) : 9'(dc);
      out_data.overflow       <= (cmd.kind == RES_FULL || cmd.kind == RES_CAP);
    end
  end

  always_comb begin
    stat             = '0;
    stat.cfg_wr      = cfg_wr;
    stat.last_elem   = (LW'(ec) + LW'(1)) == len_eff;
    stat.cap_full    = (vc == VW'(MAX_VECTORS));
    stat.sweep_done  = (sweep_idx == SLOT_LAST);
    stat.slot_valid  = slot_rd[SLW-1];
    stat.tag_hit     = (slot_rd[SLW-2:RW] == hash);
    stat.probes_last = (probes == (SW + 1)'(TABLE_SLOTS - 1));
    stat.cmp_equal   = (rda == rdb);
    stat.cmp_last    = (LW'(k) + LW'(1)) == len_eff;
    stat.out_free    = !out_valid || !out_stall;
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");
  a_vc_bound: assert property (@(posedge clk) disable iff (rst)
    vc <= VW'(MAX_VECTORS))
    else $error("vector count beyond capacity");
  a_dc_bound: assert property (@(posedge clk) disable iff (rst)
    dc <= vc)
    else $error("distinct count above vector count");

endmodule
`default_nettype wire

// ===== rtl/vector_dedup_hash_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An element that does not end a vector is taken while the controller stays idle; a
// vector end then reads and checks each probed slot, reads and checks each element
// compared on a tag hit, and then loads the result register.
// Throughput: one element per cycle while a vector streams in.
// Reset, clear command and length write each run a sweep over every slot of the
// slot table, one slot a cycle, during which no input transfers.
// ----------------------------------------------------------------------------
// Vector dedup hash table unit
// Streams vector elements, looks each completed vector up in a linear-probing
// hash table and reports its first identical index and the distinct count.
// ----------------------------------------------------------------------------
module vector_dedup_hash_table_unit
  import vdh_pkg::*;
#(
  parameter int MAX_VECTORS = 256,
  parameter int MAX_DIM     = 64,
  parameter int TABLE_SLOTS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire vdh_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output vdh_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  vdh_cmd_t  ctl_cmd;
  vdh_stat_t dp_stat;

  // Take elements only while the controller sits idle.
  assign in_stall = !ctl_cmd.ready;
  assign pready   = 1'b1;

  vdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  vdh_dp #(
    .MAX_VECTORS (MAX_VECTORS),
    .MAX_DIM     (MAX_DIM),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .in_data   (in_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== bench/tb_vector_dedup_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector dedup hash table unit testbench
// Streams vectors element by element with random gaps on both sides, predicts
// the first identical index and distinct count of every completed vector,
// and checks each result transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_vector_dedup_hash_table_unit;
  import vdh_pkg::*;

  localparam int CAPACITY   = 256;
  localparam int DIM_LIMIT  = 64;
  localparam int CYCLE_CAP  = 4000000;
  localparam int SETTLE     = 1500;   // wait after draining results, covering a full sweep

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  vdh_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  vdh_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vector_dedup_hash_table_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Dedup predictor state
  logic [6:0]  len_reg;
  int          elem_pos;
  int          vec_cnt;
  int          distinct_cnt;
  logic [15:0] row_mem [CAPACITY][DIM_LIMIT];
  bit          row_first [CAPACITY];
  logic [15:0] pending_row [DIM_LIMIT];
  vdh_out_t    dedup_q [$];

  int          mismatches;
  int          cycle_cnt;
  int          hold_left;
  int          rx_gap;
  logic [15:0] pool [4][DIM_LIMIT];

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    cycle_cnt = 0;
    forever begin
      #4 clk = ~clk;
      if (clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
          $display("vector_dedup_hash_table_unit verification failed");
          $finish;
        end
      end
    end
  end

  function automatic int active_len();
    if (len_reg == 0) return 1;
    if (len_reg > DIM_LIMIT) return DIM_LIMIT;
    return len_reg;
  endfunction

  function automatic void reset_counts();
    elem_pos = 0;
    vec_cnt = 0;
    distinct_cnt = 0;
  endfunction

  // Advance the predictor by one accepted input transfer
  function automatic void predict_dedup(logic cmd, logic [15:0] elem);
    int       n;
    int       hit;
    bit       same;
    vdh_out_t r;
    n = active_len();
    hit = -1;
    if (cmd == CMD_CLEAR) begin
      reset_counts();
      return;
    end
    pending_row[elem_pos] = elem;
    elem_pos++;
    if (elem_pos < n) return;
    elem_pos = 0;
    r = '0;
    if (vec_cnt >= CAPACITY) begin
      r.vector_index = 8'(CAPACITY);
      r.distinct_count = 9'(distinct_cnt);
      r.overflow = 1'b1;
      dedup_q.push_back(r);
      return;
    end
    for (int id = 0; id < vec_cnt && hit < 0; id++) begin
      if (row_first[id]) begin
        same = 1;
        for (int k = 0; k < n; k++)
          if (row_mem[id][k] != pending_row[k]) same = 0;
        if (same) hit = id;
      end
    end
    for (int k = 0; k < n; k++) row_mem[vec_cnt][k] = pending_row[k];
    r.vector_index = 8'(vec_cnt);
    if (hit >= 0) begin
      row_first[vec_cnt] = 0;
      r.unique_id = 8'(hit);
    end else begin
      row_first[vec_cnt] = 1;
      distinct_cnt++;
      r.unique_id = 8'(vec_cnt);
      r.is_new = 1'b1;
    end
    r.distinct_count = 9'(distinct_cnt);
    vec_cnt++;
    dedup_q.push_back(r);
  endfunction

  task automatic report(string what, int got, int want);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
  endtask

  // Receiver: random stall per result, plus the long hold-off
  always @(posedge clk) begin
    vdh_out_t w;
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dedup_q.size() == 0) begin
          report("unexpected result", out_data.vector_index, -1);
        end else begin
          w = dedup_q.pop_front();
          if (out_data.vector_index !== w.vector_index)
            report("vector_index", out_data.vector_index, w.vector_index);
          if (out_data.unique_id !== w.unique_id)
            report("unique_id", out_data.unique_id, w.unique_id);
          if (out_data.is_new !== w.is_new)
            report("is_new", out_data.is_new, w.is_new);
          if (out_data.distinct_count !== w.distinct_count)
            report("distinct_count", out_data.distinct_count, w.distinct_count);
          if (out_data.overflow !== w.overflow)
            report("overflow", out_data.overflow, w.overflow);
        end
        rx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Send one transfer after a random gap; hold the payload while stalled
  task automatic send_item(logic cmd, logic [15:0] elem, bit burst = 0);
    int gap;
    vdh_in_t d;
    gap = (burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    d.cmd = cmd;
    d.element = elem;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    predict_dedup(cmd, elem);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain results, then give the block time to finish any partial work
  task automatic wait_idle();
    drop_valid();
    while (dedup_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(logic [6:0] v);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_VECTOR_LENGTH, 2'b00};
    pwdata <= {25'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    len_reg = v;
    reset_counts();
    @(posedge clk);
  endtask

  task automatic send_vector(int pick);
    for (int k = 0; k < active_len(); k++)
      send_item(CMD_PUSH, (pick >= 0) ? pool[pick][k] : 16'($urandom));
  endtask

  task automatic test_extremes();
    write_length(7'd1);
    send_item(CMD_PUSH, 16'h8000);
    send_item(CMD_PUSH, 16'h7FFF);
    send_item(CMD_PUSH, 16'h0000);
    send_item(CMD_PUSH, 16'h8000);
    send_item(CMD_PUSH, 16'hFFFF);
    send_item(CMD_CLEAR, 16'hFFFF);
    send_item(CMD_PUSH, 16'h7FFF);
    write_length(7'd0);   // acts as one element
    send_item(CMD_PUSH, 16'h5555);
    send_item(CMD_PUSH, 16'hAAAA);
    send_item(CMD_PUSH, 16'h5555);
    write_length(7'd127); // clamps to the maximum dimension
    send_vector(0);
    send_vector(0);
    write_length(7'd64);
    send_vector(1);
    send_vector(1);
  endtask

  task automatic test_capacity();
    write_length(7'd1);
    for (int v = 0; v < CAPACITY + 6; v++)
      send_item(CMD_PUSH, 16'(v * 257), 1);
    send_item(CMD_CLEAR, 16'h0000);
    send_item(CMD_PUSH, 16'h1234);
  endtask

  task automatic test_backpressure();
    write_length(7'd1);
    @(posedge clk);
    hold_left <= 400;
    for (int k = 0; k < 60; k++)
      send_item(CMD_PUSH, 16'($urandom_range(0, 7)), 1);
  endtask

  task automatic test_random();
    int lens [5] = '{2, 3, 1, 4, 7};
    int budget;
    foreach (lens[p]) begin
      write_length(7'(lens[p]));
      budget = 0;
      while (budget < 100) begin
        if ($urandom_range(0, 29) == 0) begin
          send_item(CMD_CLEAR, 16'($urandom));
          budget++;
        end else if ($urandom_range(0, 19) == 0) begin
          // one element then a clear; cuts a vector short when the length exceeds one
          send_item(CMD_PUSH, 16'($urandom));
          send_item(CMD_CLEAR, 16'($urandom));
          budget += 2;
        end else begin
          send_vector(($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : -1);
          budget += lens[p];
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_left = 0;
    mismatches = 0;
    len_reg = LEN_RESET;
    reset_counts();
    foreach (pool[i, k]) pool[i][k] = ($urandom_range(0, 1)) ? 16'($urandom) :
                                      16'($urandom_range(0, 3));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_capacity();
    test_backpressure();
    test_random();

    drop_valid();
    while (dedup_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("vector_dedup_hash_table_unit verification clean");
    end else begin
      $display("vector_dedup_hash_table_unit verification failed");
    end
    $finish;
  end

endmodule
